/* rtl/note_priority_voice_allocator_core_macros.svh */
// Assertion macros for the checker of the voice allocator.
// Depends on nothing; included by the checker only.
`ifndef NOTE_PRIORITY_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define NOTE_PRIORITY_VOICE_ALLOCATOR_CORE_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define NPVA_ASSERT_SAME(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define NPVA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* rtl/npva_pkg.sv */
// Package of the note-priority voice allocator: payload types, constants, states.
// Depends on nothing; used by every module of the block.
package npva_pkg;

	localparam int STACK_DEPTH_DEF = 20;
	localparam int VOICES_DEF = 3;
	localparam int NOTE_W = 7;
	localparam int VOICE_W = 2;

	localparam logic [1:0] MODE_RECENT = 2'd0;
	localparam logic [1:0] MODE_HIGH = 2'd1;
	localparam logic [1:0] MODE_LOW = 2'd2;

	localparam logic KIND_PITCH = 1'b0;
	localparam logic KIND_GATE = 1'b1;

	typedef struct packed {
		logic [6:0] note;
		logic note_on;
		logic [3:0] channel;
	} in_beat_t;

	typedef struct packed {
		logic kind;
		logic [1:0] voice;
		logic [6:0] pitch_note;
		logic gate_on;
		logic [3:0] gate_channel;
		logic last;
	} out_beat_t;

	// Commands the sequencer gives the cell row for one cycle.
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_REMOVE,
		CMD_SCAN,
		CMD_POP
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [6:0] data;
		logic head;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_ON_OUT,
		ST_GATE_OUT,
		ST_OFF_DECIDE,
		ST_SCAN,
		ST_POP,
		ST_PUSHBACK,
		ST_EMIT
	} state_t;

endpackage

/* rtl/npva_cell.sv */
// One cell of the held-note row: an entry, its valid flag and local compare logic.
// Depends on npva_pkg.
module npva_cell (
	input logic clk,
	input logic arst_n,
	input npva_pkg::cell_ctl_t ctl,
	input logic [6:0] nxt_note,
	input logic nxt_valid,
	input logic prv_valid,
	input logic shift_in,
	output logic shift_out,
	output logic [6:0] note,
	output logic valid
);

	logic [6:0] note_q;
	logic valid_q;
	logic hit;
	logic shift;

	assign note = note_q;
	assign valid = valid_q;
	assign hit = valid_q && (note_q == ctl.data);
	// shift_in marks that an earlier cell matched; removal closes the gap here.
	assign shift = shift_in || hit;
	assign shift_out = shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q <= '0;
			valid_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				npva_pkg::CMD_PUSH: begin
					if (ctl.head) begin
						note_q <= nxt_note;
						valid_q <= nxt_valid;
					end else if (!valid_q && prv_valid) begin
						note_q <= ctl.data;
						valid_q <= 1'b1;
					end
				end
				npva_pkg::CMD_REMOVE: begin
					if (shift) begin
						note_q <= nxt_valid ? nxt_note : '0;
						valid_q <= nxt_valid;
					end
				end
				npva_pkg::CMD_POP: begin
					// The last valid cell holds the most recent note and drops it.
					if (valid_q && !nxt_valid) begin
						note_q <= '0;
						valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/npva_row.sv */
// Row of held-note cells with the first-match chain and the full-row shift.
// Depends on npva_pkg and npva_cell.
module npva_row #(
	parameter int STACK_DEPTH = npva_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input npva_pkg::cmd_t cmd,
	input logic [6:0] data,
	input logic full,
	output logic [STACK_DEPTH*7-1:0] notes,
	output logic found
);

	logic [STACK_DEPTH:0] chain;
	logic [6:0] n_arr [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] v_arr;

	assign chain[0] = 1'b0;
	assign found = chain[STACK_DEPTH];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		npva_pkg::cell_ctl_t ctl;
		logic [6:0] nn;
		logic nv;
		logic pv;
		always_comb begin
			ctl.cmd = cmd;
			ctl.data = data;
			ctl.head = 1'b0;
			if (cmd == npva_pkg::CMD_PUSH && full) begin
				ctl.head = 1'b1;
			end
		end
		if (i == STACK_DEPTH - 1) begin : g_top
			assign nn = data;
			assign nv = (cmd == npva_pkg::CMD_PUSH);
		end else begin : g_mid
			assign nn = n_arr[i+1];
			assign nv = v_arr[i+1];
		end
		if (i == 0) begin : g_bot
			assign pv = 1'b1;
		end else begin : g_up
			assign pv = v_arr[i-1];
		end
		npva_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.nxt_note(nn),
			.nxt_valid(nv),
			.prv_valid(pv),
			.shift_in(chain[i]),
			.shift_out(chain[i+1]),
			.note(n_arr[i]),
			.valid(v_arr[i])
		);
		assign notes[i*7 +: 7] = n_arr[i];
	end

endmodule

/* rtl/note_priority_voice_allocator_core.sv */
// Note-priority voice allocator: one event in, zero to three result beats out.
// The block is busy from start until the last result.
// A new event is taken only when the block is idle; a start while busy is not taken.
// Results cannot be stalled; each is shown for one cycle under strobe.
// Reset empties the stack, frees all voices and sets most-recent priority.
// Depends on npva_pkg and npva_row.
module note_priority_voice_allocator_core #(
	parameter int STACK_DEPTH = npva_pkg::STACK_DEPTH_DEF,
	parameter int VOICES = npva_pkg::VOICES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input npva_pkg::in_beat_t in_beat,
	output logic busy,
	input logic cfg_we,
	input logic [1:0] cfg_wdata,
	output logic strobe,
	output npva_pkg::out_beat_t out_beat
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	npva_pkg::state_t state_q, state_d;
	logic [1:0] mode_q;
	npva_pkg::in_beat_t ev_q;
	logic [CW-1:0] count_q, count_d;
	logic [6:0] vnote_q [VOICES];
	logic [VOICES-1:0] vfree_q;
	logic [6:0] got_q [VOICES];
	logic [VOICES-1:0] ok_q;
	logic [1:0] idx_q, idx_d;
	logic [IW-1:0] scan_q;
	logic [6:0] best_q;
	logic [1:0] voice_q;
	logic busy_q;
	npva_pkg::out_beat_t ob_d;
	logic strobe_d;

	npva_pkg::cmd_t cmd;
	logic [6:0] cdata;
	logic [STACK_DEPTH*7-1:0] notes;
	logic found;
	logic full;
	logic [6:0] cur;

	assign full = (count_q == CW'(STACK_DEPTH));
	assign cur = notes[scan_q*7 +: 7];

	npva_row #(.STACK_DEPTH(STACK_DEPTH)) u_row (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.data(cdata),
		.full(full),
		.notes(notes),
		.found(found)
	);

	logic free_any;
	logic [1:0] free_v;
	logic match_any;
	logic [1:0] match_v;
	always_comb begin
		free_any = 1'b0;
		free_v = '0;
		match_any = 1'b0;
		match_v = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (vfree_q[v]) begin
				free_any = 1'b1;
				free_v = 2'(v);
			end
			if (!vfree_q[v] && vnote_q[v] == ev_q.note) begin
				match_any = 1'b1;
				match_v = 2'(v);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = npva_pkg::CMD_HOLD;
		cdata = ev_q.note;
		count_d = count_q;
		idx_d = idx_q;
		ob_d = '0;
		strobe_d = 1'b0;
		unique case (state_q)
			npva_pkg::ST_IDLE: begin
				if (start) begin
					state_d = in_beat.note_on ? npva_pkg::ST_ON_OUT : npva_pkg::ST_REMOVE;
				end
			end
			npva_pkg::ST_REMOVE: begin
				cmd = npva_pkg::CMD_REMOVE;
				if (found) begin
					count_d = count_q - 1'b1;
				end
				state_d = npva_pkg::ST_OFF_DECIDE;
			end
			npva_pkg::ST_OFF_DECIDE: begin
				if (count_q > CW'(VOICES - 1)) begin
					idx_d = '0;
					state_d = npva_pkg::ST_SCAN;
				end else begin
					if (match_any) begin
						strobe_d = 1'b1;
						ob_d.kind = npva_pkg::KIND_GATE;
						ob_d.voice = match_v;
						ob_d.pitch_note = ev_q.note;
						ob_d.gate_channel = ev_q.channel;
						ob_d.last = 1'b1;
					end
					state_d = npva_pkg::ST_IDLE;
				end
			end
			npva_pkg::ST_ON_OUT: begin
				cmd = npva_pkg::CMD_PUSH;
				if (!full) begin
					count_d = count_q + 1'b1;
				end
				if (free_any) begin
					strobe_d = 1'b1;
					ob_d.kind = npva_pkg::KIND_PITCH;
					ob_d.voice = free_v;
					ob_d.pitch_note = ev_q.note;
					state_d = npva_pkg::ST_GATE_OUT;
				end else begin
					idx_d = '0;
					state_d = npva_pkg::ST_SCAN;
				end
			end
			npva_pkg::ST_GATE_OUT: begin
				strobe_d = 1'b1;
				ob_d.kind = npva_pkg::KIND_GATE;
				ob_d.voice = voice_q;
				ob_d.pitch_note = ev_q.note;
				ob_d.gate_on = 1'b1;
				ob_d.gate_channel = ev_q.channel;
				ob_d.last = 1'b1;
				state_d = npva_pkg::ST_IDLE;
			end
			npva_pkg::ST_SCAN: begin
				if (count_q == '0) begin
					state_d = npva_pkg::ST_POP;
				end else if ({1'b0, scan_q} + 1'b1 >= (CW+1)'(count_q)) begin
					state_d = npva_pkg::ST_POP;
				end
			end
			npva_pkg::ST_POP: begin
				if (count_q != '0) begin
					if (mode_q == npva_pkg::MODE_HIGH || mode_q == npva_pkg::MODE_LOW) begin
						cmd = npva_pkg::CMD_REMOVE;
					end else begin
						cmd = npva_pkg::CMD_POP;
					end
					cdata = best_q;
					count_d = count_q - 1'b1;
				end
				if (idx_q == 2'(VOICES - 1)) begin
					idx_d = 2'(VOICES - 1);
					state_d = npva_pkg::ST_PUSHBACK;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = npva_pkg::ST_SCAN;
				end
			end
			npva_pkg::ST_PUSHBACK: begin
				if (ok_q[idx_q]) begin
					cmd = npva_pkg::CMD_PUSH;
					cdata = got_q[idx_q];
					if (!full) begin
						count_d = count_q + 1'b1;
					end
				end
				if (idx_q == '0) begin
					state_d = npva_pkg::ST_EMIT;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			npva_pkg::ST_EMIT: begin
				strobe_d = 1'b1;
				ob_d.kind = npva_pkg::KIND_PITCH;
				ob_d.voice = idx_q;
				ob_d.pitch_note = got_q[idx_q];
				if (idx_q == 2'(VOICES - 1)) begin
					ob_d.last = 1'b1;
					state_d = npva_pkg::ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = npva_pkg::ST_IDLE;
			end
		endcase
	end

	// Removal by value hits the first match, so the popped entry must be the
	// first occurrence of the best value; the scan keeps the earliest on ties.
	// For most recent the top entry is dropped by position.
	logic better;
	always_comb begin
		unique case (mode_q)
			npva_pkg::MODE_HIGH: better = cur > best_q;
			npva_pkg::MODE_LOW: better = cur < best_q;
			default: better = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npva_pkg::ST_IDLE;
			mode_q <= npva_pkg::MODE_RECENT;
			count_q <= '0;
			vfree_q <= '1;
			idx_q <= '0;
			scan_q <= '0;
			busy_q <= 1'b0;
			strobe <= 1'b0;
			for (int v = 0; v < VOICES; v++) begin
				vnote_q[v] <= '0;
			end
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q <= idx_d;
			strobe <= strobe_d;
			busy_q <= (state_d != npva_pkg::ST_IDLE);
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (state_q == npva_pkg::ST_ON_OUT && free_any) begin
				vfree_q[free_v] <= 1'b0;
				vnote_q[free_v] <= ev_q.note;
			end
			if (state_q == npva_pkg::ST_OFF_DECIDE && count_q <= CW'(VOICES - 1)
				&& match_any) begin
				vfree_q[match_v] <= 1'b1;
			end
			if (state_q == npva_pkg::ST_EMIT) begin
				vnote_q[idx_q] <= got_q[idx_q];
			end
			if (state_d == npva_pkg::ST_SCAN && state_q != npva_pkg::ST_SCAN) begin
				scan_q <= '0;
			end else if (state_q == npva_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == npva_pkg::ST_IDLE && start) begin
			ev_q <= in_beat;
		end
		if (state_q == npva_pkg::ST_ON_OUT) begin
			voice_q <= free_v;
		end
		if (state_q == npva_pkg::ST_SCAN) begin
			if (scan_q == '0 || better) begin
				best_q <= cur;
			end
		end
		if (state_q == npva_pkg::ST_POP) begin
			got_q[idx_q] <= (count_q != '0) ? best_q : 7'd0;
			ok_q[idx_q] <= (count_q != '0);
		end
		out_beat <= ob_d;
	end

	assign busy = busy_q || (state_q != npva_pkg::ST_IDLE);

endmodule

/* rtl/npva_checker.sv */
// Port-level checker of the voice allocator, bound to the top level.
// Depends on npva_pkg and the assertion macro header.
`include "note_priority_voice_allocator_core_macros.svh"

module npva_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input npva_pkg::out_beat_t out_beat
);

	`NPVA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`NPVA_ASSERT_SAME(a_strobe_busy, clk, arst_n, strobe && !out_beat.last, busy)
	`NPVA_ASSERT_SAME(a_pitch_gate, clk, arst_n, strobe && !out_beat.kind, !out_beat.gate_on)
	`NPVA_ASSERT_SAME(a_voice_range, clk, arst_n, strobe, out_beat.voice != 2'd3)

endmodule

bind note_priority_voice_allocator_core npva_checker u_npva_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.strobe(strobe),
	.out_beat(out_beat)
);
